/* rtl/core/binary_image_thinning_macros.svh */
// ----------------------------------------------------------------------------
// Binary image thinning: assertion macros
// Shared property shorthands, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_IMAGE_THINNING_MACROS_SVH
`define BINARY_IMAGE_THINNING_MACROS_SVH

// Same-cycle implication.
`define BIT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bit_pkg.sv */
// ----------------------------------------------------------------------------
// Binary image thinning package
// Widths, row type, register indexes and the row evaluator control word.
// ----------------------------------------------------------------------------
package bit_pkg;

  localparam int unsigned ROW_W      = 64;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned ITER_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(3);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = CFG_IDX_W'(2);

  typedef logic [ROW_W-1:0] row_t;

  // Control word for the row evaluator
  typedef struct packed {
    logic second;    // second sub-pass corner rule
    row_t interior;  // columns that may be deleted
  } eval_ctl_t;

endpackage

/* rtl/core/bit_store.sv */
// ----------------------------------------------------------------------------
// Image row store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bit_store
  import bit_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  row_t             wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output row_t             rd_data_o
);

  row_t mem_q [Depth];
  row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/bit_row_eval.sv */
// ----------------------------------------------------------------------------
// Row evaluator
// Applies the thinning pixel test to every column of one centre row at once.
// ----------------------------------------------------------------------------
module bit_row_eval
  import bit_pkg::*;
(
  input  row_t      up_i,
  input  row_t      mid_i,
  input  row_t      dn_i,
  input  eval_ctl_t ctl_i,
  output row_t      del_o
);

  // Neighbourhood bits: [0] west column, [1] centre, [2] east column.
  function automatic logic pixel_del(logic [2:0] u, logic [2:0] m, logic [2:0] d,
                                     logic second);
    logic       e, ne, n, nw, wv, sw, s, se;
    logic [2:0] c, n1, n2, nm;
    logic       corner;
    e  = m[2];
    ne = u[2];
    n  = u[1];
    nw = u[0];
    wv = m[0];
    sw = d[0];
    s  = d[1];
    se = d[2];
    c  = 3'(!e & (ne | n)) + 3'(!n & (nw | wv)) + 3'(!wv & (sw | s)) + 3'(!s & (se | e));
    n1 = 3'(e | ne) + 3'(n | nw) + 3'(wv | sw) + 3'(s | se);
    n2 = 3'(ne | n) + 3'(nw | wv) + 3'(sw | s) + 3'(se | e);
    nm = (n1 < n2) ? n1 : n2;
    if (second) begin
      corner = (sw | s | !nw) & wv;
    end else begin
      corner = (ne | n | !se) & e;
    end
    return m[1] && (c == 3'd1) && (nm >= 3'd2) && (nm <= 3'd3) && !corner;
  endfunction

  // Pad with background on both sides so edge lanes see zeros.
  logic [ROW_W+1:0] up_pad, mid_pad, dn_pad;

  assign up_pad  = {1'b0, up_i, 1'b0};
  assign mid_pad = {1'b0, mid_i, 1'b0};
  assign dn_pad  = {1'b0, dn_i, 1'b0};

  for (genvar j = 0; j < ROW_W; j++) begin : g_lane
    assign del_o[j] = ctl_i.interior[j] &
                      pixel_del(up_pad[j+2:j], mid_pad[j+2:j], dn_pad[j+2:j], ctl_i.second);
  end

endmodule

/* rtl/core/binary_image_thinning.sv */
// ----------------------------------------------------------------------------
// Binary image thinning (Guo-Hall), top level
// Loading: one row word per cycle, busy_o stays low until the final row.
// Final row: I iterations of two sub-passes, each streaming the H rows
//   through the window, then H result words on consecutive cycles, read
//   back from the row store after the last sub-pass.
// Rate is set by the single read port of the row store: one row per cycle.
// Reset: asynchronous, active low; registers return to 64/64/255, no rows.
// ----------------------------------------------------------------------------
`include "binary_image_thinning_macros.svh"

module binary_image_thinning
  import bit_pkg::*;
#(
  parameter int unsigned MaxDim = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Row input, command style
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [ROW_W-1:0]      row_pixels_i,
  // Result words, one per strobe
  output logic                  result_valid_o,
  output logic [ROW_W-1:0]      thinned_row_o,
  output logic                  last_row_o,
  output logic [ITER_W-1:0]     iterations_done_o
);

  localparam int unsigned AddrW = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam logic [DIM_W-1:0] MaxDimC = DIM_W'(MaxDim);

  // One-hot sequencer: idle/load, thinning sub-pass, emit rows.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PASS = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [DIM_W-1:0]  width_q, height_q;
  logic [ITER_W-1:0] max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= DIM_W'(64);
      height_q   <= DIM_W'(64);
      max_iter_q <= ITER_W'(255);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:    width_q    <= cfg_wdata_i[DIM_W-1:0];
        CFG_HEIGHT:   height_q   <= cfg_wdata_i[DIM_W-1:0];
        CFG_MAX_ITER: max_iter_q <= cfg_wdata_i[ITER_W-1:0];
        default: ;  // unused index: drop the word
      endcase
    end
  end

  // Saturate the dimensions into 3..MaxDim.
  logic [DIM_W-1:0] h, w;

  assign h = (height_q < DIM_MIN) ? DIM_MIN : ((height_q > MaxDimC) ? MaxDimC : height_q);
  assign w = (width_q  < DIM_MIN) ? DIM_MIN : ((width_q  > MaxDimC) ? MaxDimC : width_q);

  // Columns in use, and the interior columns 1..w-2 that may be deleted.
  row_t wmask, interior;

  assign wmask    = (w >= DIM_W'(ROW_W)) ? '1 : ((ROW_W'(1) << w) - ROW_W'(1));
  assign interior = (wmask >> 1) & ~ROW_W'(1);

  // Sequencer state
  logic [DIM_W-1:0]  rows_loaded_q, rows_loaded_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              second_q, second_d;
  logic              removed_q, removed_d;
  logic [DIM_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic [DIM_W-1:0]  rd_row_q, rd_row_d;

  // Three-row window of the sub-pass snapshot
  row_t             up_q, mid_q, dn_q;
  logic             win_vld_q;
  logic [DIM_W-1:0] win_row_q;

  // Row store ports
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  row_t             mem_wdata, mem_rdata;

  // Row evaluator
  eval_ctl_t eval_ctl;
  row_t      del;

  logic             accept, load_last;
  logic [DIM_W-1:0] load_idx, center_row;
  logic             pass_wr, pass_end, removed_now;

  assign accept = start_i & ~busy_o;

  // A row that arrives once the (lowered) height is already reached closes the image.
  assign load_idx  = (rows_loaded_q >= h) ? (h - DIM_W'(1)) : rows_loaded_q;
  assign load_last = (load_idx == (h - DIM_W'(1)));

  // The window holds rows r-2, r-1, r: rewrite the centre row once r >= 2.
  assign center_row  = win_row_q - DIM_W'(1);
  assign pass_wr     = (state_q == ST_PASS) && win_vld_q && (win_row_q >= DIM_W'(2));
  assign pass_end    = (state_q == ST_PASS) && win_vld_q && (win_row_q >= (h - DIM_W'(1)));
  assign removed_now = removed_q | (second_q & pass_wr & (|del));

  assign eval_ctl.second   = second_q;
  assign eval_ctl.interior = interior;

  always_comb begin
    state_d       = state_q;
    rows_loaded_d = rows_loaded_q;
    iter_d        = iter_q;
    second_d      = second_q;
    removed_d     = removed_q;
    rd_cnt_d      = rd_cnt_q;
    rd_vld_d      = 1'b0;
    rd_row_d      = rd_row_q;
    mem_we        = 1'b0;
    mem_waddr     = load_idx[AddrW-1:0];
    mem_wdata     = row_pixels_i;
    mem_re        = 1'b0;
    mem_raddr     = rd_cnt_q[AddrW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mem_we = 1'b1;
          if (load_last) begin
            // Image complete: start the first iteration, or emit at once.
            rows_loaded_d = '0;
            rd_cnt_d      = '0;
            second_d      = 1'b0;
            removed_d     = 1'b0;
            if (max_iter_q == '0) begin
              iter_d  = '0;
              state_d = ST_EMIT;
            end else begin
              iter_d  = ITER_W'(1);
              state_d = ST_PASS;
            end
          end else begin
            rows_loaded_d = load_idx + DIM_W'(1);
          end
        end
      end

      ST_PASS: begin
        // Stream rows in order; a row is rewritten only after its lower
        // neighbour has been read, so later reads still see the snapshot.
        if (rd_cnt_q < h) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_row_d = rd_cnt_q;
          rd_cnt_d = rd_cnt_q + DIM_W'(1);
        end
        if (pass_wr) begin
          mem_we    = 1'b1;
          mem_waddr = center_row[AddrW-1:0];
          mem_wdata = mid_q & ~del;
          removed_d = removed_now;
        end
        if (pass_end) begin
          rd_cnt_d  = '0;
          rd_vld_d  = 1'b0;
          removed_d = 1'b0;
          if (!second_q) begin
            second_d = 1'b1;
          end else if (removed_now && (iter_q < max_iter_q)) begin
            // Advance to the next iteration.
            iter_d   = iter_q + ITER_W'(1);
            second_d = 1'b0;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (rd_cnt_q < h) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_row_d = rd_cnt_q;
          rd_cnt_d = rd_cnt_q + DIM_W'(1);
        end
        if (rd_vld_q && (rd_row_q == (h - DIM_W'(1)))) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      rows_loaded_q <= '0;
      iter_q        <= '0;
      second_q      <= 1'b0;
      removed_q     <= 1'b0;
      rd_cnt_q      <= '0;
      rd_vld_q      <= 1'b0;
      rd_row_q      <= '0;
      win_vld_q     <= 1'b0;
      win_row_q     <= '0;
    end else begin
      state_q       <= state_d;
      rows_loaded_q <= rows_loaded_d;
      iter_q        <= iter_d;
      second_q      <= second_d;
      removed_q     <= removed_d;
      rd_cnt_q      <= rd_cnt_d;
      rd_vld_q      <= rd_vld_d;
      rd_row_q      <= rd_row_d;
      win_vld_q     <= rd_vld_q && (state_q == ST_PASS);
      if (rd_vld_q) begin
        win_row_q <= rd_row_q;
      end
    end
  end

  // Shift the window on each returned row; drop bits beyond the width.
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      up_q  <= mid_q;
      mid_q <= dn_q;
      dn_q  <= mem_rdata & wmask;
    end
  end

  bit_store #(
    .Depth (MaxDim),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  bit_row_eval u_eval (
    .up_i  (up_q),
    .mid_i (mid_q),
    .dn_i  (dn_q),
    .ctl_i (eval_ctl),
    .del_o (del)
  );

  // Result words come straight off the registered store read.
  assign busy_o            = (state_q != ST_IDLE);
  assign result_valid_o    = (state_q == ST_EMIT) && rd_vld_q;
  assign thinned_row_o     = mem_rdata & wmask;
  assign last_row_o        = result_valid_o && (rd_row_q == (h - DIM_W'(1)));
  assign iterations_done_o = iter_q;

  // Assertions
  `BIT_ASSERT_NEXT(a_final_row_starts, accept && load_last, busy_o, "final row did not start thinning")
  `BIT_ASSERT_IMPL(a_no_top_row_write, pass_wr, mem_waddr != '0, "sub-pass rewrote the top row")
  `BIT_ASSERT_NEXT(a_last_row_idles, result_valid_o && last_row_o, !busy_o, "block busy after last row")

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Binary image thinning testbench
// Feeds binary images into the block one row word at a time and thins each
// image in a local Guo-Hall predictor. Every emitted row word is checked
// against that prediction. A short table of hand-picked images and register
// settings comes first. Random images under random settings follow.
// ----------------------------------------------------------------------------
module tb;
  import bit_pkg::*;

  localparam int unsigned MAX_DIM     = 64;
  localparam int unsigned RANDOM_ROWS = 200;
  localparam int unsigned SETTLE_CYC  = 8;    // quiet cycles before a register write
  localparam int unsigned TAIL_CYC    = 200;  // watch for stray words at the end
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PLAN_LEN    = 34;

  // Index with no register behind it: the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

  typedef enum logic {ST_ROW, ST_REG} step_kind_e;

  // One step of the directed table: either a register write (idx, data) or a
  // row word (data), optionally with the thinned row and count typed in.
  typedef struct packed {
    step_kind_e           kind;
    logic [CFG_IDX_W-1:0] idx;
    row_t                 data;
    logic                 typed;
    row_t                 want_row;
    logic [ITER_W-1:0]    want_iter;
  } dir_step_t;

  typedef struct packed {
    row_t              pixels;
    logic              last;
    logic [ITER_W-1:0] iters;
  } out_word_t;

  // Directed table. The idx field of a row step is unused and held at zero.
  localparam dir_step_t PLAN [PLAN_LEN] = '{
    // Reset widths and limit, only the height lowered: a lone full-width line
    // is a two-sided bridge and survives; one iteration, nothing deleted.
    '{ST_REG, CFG_HEIGHT,   64'd3,                 1'b0, '0,      '0},
    '{ST_ROW, '0,           64'h0,                 1'b1, 64'h0,   8'd1},
    '{ST_ROW, '0,           '1,                    1'b1, '1,      8'd1},
    '{ST_ROW, '0,           64'h0,                 1'b1, 64'h0,   8'd1},
    // Limit of zero: no thinning, rows come back cut to eight columns.
    '{ST_REG, CFG_MAX_ITER, 64'd0,                 1'b0, '0,      '0},
    '{ST_REG, CFG_WIDTH,    64'd8,                 1'b0, '0,      '0},
    '{ST_ROW, '0,           '1,                    1'b1, 64'hFF,  8'd0},
    '{ST_ROW, '0,           '1,                    1'b1, 64'hFF,  8'd0},
    '{ST_ROW, '0,           '1,                    1'b1, 64'hFF,  8'd0},
    // Dimensions below range saturate to 3x3; garbage above the width drops.
    '{ST_REG, CFG_WIDTH,    64'd0,                 1'b0, '0,      '0},
    '{ST_REG, CFG_HEIGHT,   64'd0,                 1'b0, '0,      '0},
    '{ST_REG, CFG_MAX_ITER, 64'hFF,                1'b0, '0,      '0},
    '{ST_ROW, '0,           64'hFFFF_0000_0000_0002, 1'b0, '0,    '0},
    '{ST_ROW, '0,           64'hA5A5_0000_0000_0007, 1'b0, '0,    '0},
    '{ST_ROW, '0,           64'h0000_0000_0000_0002, 1'b0, '0,    '0},
    // Width above range saturates to 64; limit of one stops a thick bar early.
    // The write to the empty index must leave the limit alone.
    '{ST_REG, CFG_WIDTH,    64'hFF,                1'b0, '0,      '0},
    '{ST_REG, CFG_HEIGHT,   64'd5,                 1'b0, '0,      '0},
    '{ST_REG, CFG_MAX_ITER, 64'd1,                 1'b0, '0,      '0},
    '{ST_REG, CFG_UNUSED,   64'h02,                1'b0, '0,      '0},
    '{ST_ROW, '0,           64'h0,                 1'b0, '0,      '0},
    '{ST_ROW, '0,           64'h0000_0000_0000_007E, 1'b0, '0,    '0},
    '{ST_ROW, '0,           64'h8000_0000_0000_00FE, 1'b0, '0,    '0},
    '{ST_ROW, '0,           64'h0000_0000_0000_007E, 1'b0, '0,    '0},
    '{ST_ROW, '0,           64'h0,                 1'b0, '0,      '0},
    // Height lowered to four with five rows already in: the next row lands
    // in row three and completes the image.
    '{ST_REG, CFG_WIDTH,    64'd16,                1'b0, '0,      '0},
    '{ST_REG, CFG_HEIGHT,   64'd8,                 1'b0, '0,      '0},
    '{ST_REG, CFG_MAX_ITER, 64'hFF,                1'b0, '0,      '0},
    '{ST_ROW, '0,           64'h0,                 1'b0, '0,      '0},
    '{ST_ROW, '0,           64'h0FF0,              1'b0, '0,      '0},
    '{ST_ROW, '0,           64'h0FF0,              1'b0, '0,      '0},
    '{ST_ROW, '0,           64'h0FF0,              1'b0, '0,      '0},
    '{ST_ROW, '0,           64'h0FF0,              1'b0, '0,      '0},
    '{ST_REG, CFG_HEIGHT,   64'd4,                 1'b0, '0,      '0},
    '{ST_ROW, '0,           64'h0,                 1'b0, '0,      '0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  start_i;
  logic                  busy_o;
  logic [ROW_W-1:0]      row_pixels_i;
  logic                  result_valid_o;
  logic [ROW_W-1:0]      thinned_row_o;
  logic                  last_row_o;
  logic [ITER_W-1:0]     iterations_done_o;

  // Predictor state: the image as it builds up, typed-in expectations kept
  // by row position, and the register copies.
  row_t              pic_rows   [MAX_DIM];
  logic              typed_here [MAX_DIM];
  row_t              typed_row  [MAX_DIM];
  logic [ITER_W-1:0] typed_iter [MAX_DIM];
  int                rows_in;
  logic [DIM_W-1:0]  reg_width;
  logic [DIM_W-1:0]  reg_height;
  logic [ITER_W-1:0] reg_iter_limit;

  out_word_t pending_words [$];

  int failures;
  int rows_fed;
  int images_done;
  int words_seen;
  int regs_written;
  int deepest;

  binary_image_thinning u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run (every image running to the
  // iteration limit, every row word held off by the longest sender gap).
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int sat_dim(logic [DIM_W-1:0] v);
    if (v < DIM_MIN) return int'(DIM_MIN);
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic row_t col_mask(int w);
    if (w >= ROW_W) return {ROW_W{1'b1}};
    return (row_t'(1) << w) - row_t'(1);
  endfunction

  // One Guo-Hall sub-pass over the interior against a frozen snapshot;
  // marked pixels are cleared together. Returns the number deleted.
  function automatic int guo_hall_pass(int h, int w, bit second);
    row_t kill [MAX_DIM];
    int   cnt;
    bit   e, ne, n, nw, wv, sw, s, se, corner;
    int   c, n1, n2, nm;
    cnt = 0;
    for (int i = 0; i < MAX_DIM; i++) kill[i] = '0;
    for (int i = 1; i + 1 < h; i++) begin
      for (int j = 1; j + 1 < w; j++) begin
        if (pic_rows[i][j]) begin
          e  = pic_rows[i][j+1];
          ne = pic_rows[i-1][j+1];
          n  = pic_rows[i-1][j];
          nw = pic_rows[i-1][j-1];
          wv = pic_rows[i][j-1];
          sw = pic_rows[i+1][j-1];
          s  = pic_rows[i+1][j];
          se = pic_rows[i+1][j+1];
          // connectivity: 0 -> 1 transitions around the ring
          c  = int'(!e && (ne || n)) + int'(!n && (nw || wv))
             + int'(!wv && (sw || s)) + int'(!s && (se || e));
          n1 = int'(e || ne) + int'(n || nw) + int'(wv || sw) + int'(s || se);
          n2 = int'(ne || n) + int'(nw || wv) + int'(sw || s) + int'(se || e);
          nm = (n1 < n2) ? n1 : n2;
          corner = second ? ((sw || s || !nw) && wv) : ((ne || n || !se) && e);
          if (c == 1 && nm >= 2 && nm <= 3 && !corner) begin
            kill[i][j] = 1'b1;
            cnt++;
          end
        end
      end
    end
    for (int i = 0; i < MAX_DIM; i++) pic_rows[i] &= ~kill[i];
    return cnt;
  endfunction

  // Take one accepted row word; on the final row thin the image and queue
  // every row word the block owes.
  function automatic void accept_row(row_t px, logic typed, row_t t_row,
                                     logic [ITER_W-1:0] t_iter);
    int        h, w, iters, removed;
    row_t      keep;
    out_word_t word;
    h = sat_dim(reg_height);
    w = sat_dim(reg_width);
    rows_fed++;
    // height lowered under a part-loaded image: this row closes it
    if (rows_in >= h) rows_in = h - 1;
    pic_rows[rows_in]   = px;
    typed_here[rows_in] = typed;
    typed_row[rows_in]  = t_row;
    typed_iter[rows_in] = t_iter;
    rows_in++;
    if (rows_in < h) return;

    keep = col_mask(w);
    for (int k = 0; k < h; k++) pic_rows[k] &= keep;
    iters   = 0;
    removed = 1;
    // only the second sub-pass decides whether another iteration runs
    while (iters < reg_iter_limit && removed > 0) begin
      iters++;
      void'(guo_hall_pass(h, w, 1'b0));
      removed = guo_hall_pass(h, w, 1'b1);
    end
    for (int k = 0; k < h; k++) begin
      word.pixels = typed_here[k] ? typed_row[k] : (pic_rows[k] & keep);
      word.last   = (k == h - 1);
      word.iters  = typed_here[k] ? typed_iter[k] : ITER_W'(iters);
      pending_words.push_back(word);
      typed_here[k] = 1'b0;
    end
    rows_in = 0;
    images_done++;
    if (iters > deepest) deepest = iters;
  endfunction

  function automatic void log_failure(string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Hold the strobe low and drain the block before a register write.
  task automatic settle();
    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WIDTH:    reg_width      = val[DIM_W-1:0];
      CFG_HEIGHT:   reg_height     = val[DIM_W-1:0];
      CFG_MAX_ITER: reg_iter_limit = val[ITER_W-1:0];
      default: ;  // empty index: no register changes
    endcase
    regs_written++;
    // a quiet wait with the enable low so it never drops and rises in one step
    @(posedge clk_i);
  endtask

  // Drop the strobe for a random burst now and then, never when quiet.
  task automatic maybe_pause(bit quiet);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Present one row word and hold it until the block takes it.
  task automatic feed_row(row_t px, logic typed, row_t t_row, logic [ITER_W-1:0] t_iter);
    start_i      <= 1'b1;
    row_pixels_i <= px;
    do @(posedge clk_i); while (busy_o);
    accept_row(px, typed, t_row, t_iter);
  endtask

  // Result monitor: every strobed word must match the oldest expectation.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && result_valid_o) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        log_failure($sformatf("unexpected row word %h (last %b, iterations %0d)",
                              thinned_row_o, last_row_o, iterations_done_o));
      end else begin
        want = pending_words.pop_front();
        if (thinned_row_o !== want.pixels || last_row_o !== want.last ||
            iterations_done_o !== want.iters) begin
          log_failure($sformatf(
            "row word mismatch: got %h last %b iter %0d, wanted %h last %b iter %0d",
            thinned_row_o, last_row_o, iterations_done_o,
            want.pixels, want.last, want.iters));
        end
      end
    end
  end

  initial begin
    int                    h, w, style, lo, hi, top, bot, sent, phase, n_img;
    row_t                  px, bar, n1, n2;
    logic [CFG_DATA_W-1:0] wval, hval, lval;
    bit                    quiet;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_WIDTH;
    cfg_wdata_i    = '0;
    start_i        = 1'b0;
    row_pixels_i   = '0;
    reg_width      = DIM_W'(MAX_DIM);
    reg_height     = DIM_W'(MAX_DIM);
    reg_iter_limit = '1;
    rows_in        = 0;
    failures       = 0;
    rows_fed       = 0;
    images_done    = 0;
    words_seen     = 0;
    regs_written   = 0;
    deepest        = 0;
    for (int i = 0; i < MAX_DIM; i++) typed_here[i] = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table.
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ST_REG) begin
        settle();
        write_reg(PLAN[i].idx, PLAN[i].data[CFG_DATA_W-1:0]);
      end else begin
        maybe_pause(1'b0);
        feed_row(PLAN[i].data, PLAN[i].typed, PLAN[i].want_row, PLAN[i].want_iter);
      end
    end

    // Random phases: new settings, then one to three images under them.
    // Mostly small images with solid blobs that need several iterations;
    // the second phase is a full 64x64 image.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ROWS) begin
      if (phase == 1) begin
        wval = CFG_DATA_W'($urandom_range(64, 127));
        hval = CFG_DATA_W'($urandom_range(64, 127));
      end else begin
        case ($urandom_range(0, 9))
          0:       wval = CFG_DATA_W'($urandom_range(0, 2));
          1:       wval = CFG_DATA_W'($urandom_range(64, 255));
          default: wval = CFG_DATA_W'($urandom_range(3, 16));
        endcase
        hval = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                           : CFG_DATA_W'($urandom_range(3, 10));
      end
      case ($urandom_range(0, 7))
        0:       lval = '0;
        1:       lval = CFG_DATA_W'(1);
        2:       lval = CFG_DATA_W'($urandom_range(2, 6));
        3:       lval = CFG_DATA_W'($urandom_range(0, 255));
        default: lval = '1;
      endcase
      settle();
      write_reg(CFG_WIDTH, wval);
      write_reg(CFG_HEIGHT, hval);
      write_reg(CFG_MAX_ITER, lval);
      h = sat_dim(reg_height);
      w = sat_dim(reg_width);

      n_img = (phase == 1) ? 1 : $urandom_range(1, 3);
      for (int m = 0; m < n_img; m++) begin
        style = $urandom_range(0, 9);
        lo    = $urandom_range(0, w / 2);
        hi    = $urandom_range(lo, (w < ROW_W) ? w : ROW_W - 1);
        top   = $urandom_range(0, h / 2);
        bot   = $urandom_range(top, h - 1);
        bar   = ((row_t'(1) << (hi - lo + 1)) - row_t'(1)) << lo;
        for (int r = 0; r < h; r++) begin
          n1 = {$urandom, $urandom};
          n2 = {$urandom, $urandom};
          case (style)
            0:          px = n1;                                // raw noise
            1:          px = n1 | n2;                           // dense noise
            2, 3, 4, 5: px = (r >= top && r <= bot) ? bar : '0; // solid blob
            default: begin                                      // blob with holes
              px = (r >= top && r <= bot) ? (bar & ~(n1 & n2 & {$urandom, $urandom}))
                                          : (n1 & n2 & {$urandom, $urandom});
            end
          endcase
          // ragged edges
          if ($urandom_range(0, 2) == 0) px = $urandom_range(0, 1) ? (px << 1) : (px >> 1);
          quiet = (sent >= RANDOM_ROWS * 3 / 4);
          maybe_pause(quiet);
          feed_row(px, 1'b0, '0, '0);
          sent++;
        end
      end
      phase++;
    end

    // Drain, then watch a while longer for stray words.
    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
    failures += pending_words.size();

    $display("Thinned %0d images from %0d rows over %0d register writes, deepest %0d iterations.",
             images_done, rows_fed, regs_written, deepest);
    $display("Checked %0d row words, %0d mismatches.", words_seen, failures);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
